// File: design/rds_pkg.sv
// ----------------------------------------------------------------------------
// rds_pkg
// Shared types and constants of the relative difference search unit.
// ----------------------------------------------------------------------------
package rds_pkg;

	localparam int BYTE_W     = 8;
	localparam int WL_W       = 5;
	localparam int DIFF_W     = 64;
	localparam int OUT_ADDR_W = 24;
	localparam int CFG_IDX_W  = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFFS_LOW   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFFS_HIGH  = 2'd2;

	localparam logic [WL_W-1:0] WL_RESET = 5'd2;
	localparam logic [WL_W-1:0] WL_MIN   = 5'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              stream_start;
	} in_item_t;

	typedef struct packed {
		logic [OUT_ADDR_W-1:0] match_address;
		logic [BYTE_W-1:0]     matched_byte;
		logic                  last_byte;
	} out_item_t;

	// report request from the scanner to the report sequencer
	typedef struct packed {
		logic                  start;
		logic [BYTE_W-1:0]     tail_byte;
		logic [OUT_ADDR_W-1:0] address;
	} rds_req_t;

endpackage

// File: design/rds_stream_if.sv
// ----------------------------------------------------------------------------
// rds_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface rds_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: design/rds_ram.sv
// ----------------------------------------------------------------------------
// rds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/rds_scan.sv
// ----------------------------------------------------------------------------
// rds_scan
// Byte scanner: pairs each byte with its predecessor, matches differences,
// stores matched bytes and raises a report request on a full match.
// ----------------------------------------------------------------------------
module rds_scan
	import rds_pkg::*;
#(
	parameter int MAX_WORD      = 16,
	parameter int ADDRESS_WIDTH = 24,
	localparam int CW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIFF_W-1:0]    cfg_wdata,
	input  logic                 accept,
	input  in_item_t             item,
	output logic                 ram_we,
	output logic [CW-1:0]        ram_waddr,
	output logic [BYTE_W-1:0]    ram_wdata,
	output rds_req_t             req,
	output logic [CW-1:0]        req_last
);

	logic [WL_W-1:0]          wl_q;
	logic [DIFF_W-1:0]        diffs_low_q;
	logic [DIFF_W-1:0]        diffs_high_q;
	logic [BYTE_W-1:0]        prev_q;
	logic                     have_q;
	logic [ADDRESS_WIDTH-1:0] pos_q;
	logic [CW-1:0]            cnt_q;
	logic [ADDRESS_WIDTH-1:0] mstart_q;

	logic [2*DIFF_W-1:0]      diffs_all;
	logic [ADDRESS_WIDTH-1:0] addr;
	logic                     have;
	logic [CW-1:0]            cnt;
	logic [ADDRESS_WIDTH-1:0] mstart;
	logic [ADDRESS_WIDTH-1:0] mstart_new;
	logic [BYTE_W-1:0]        cur;
	logic [BYTE_W-1:0]        diff;
	logic [BYTE_W-1:0]        expected;
	logic [WL_W-1:0]          len_eff;
	logic                     hit;
	logic                     done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q         <= WL_RESET;
			diffs_low_q  <= '0;
			diffs_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WORD_LENGTH: wl_q         <= cfg_wdata[WL_W-1:0];
				CFG_DIFFS_LOW:   diffs_low_q  <= cfg_wdata;
				CFG_DIFFS_HIGH:  diffs_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		cur       = item.data_byte;
		addr      = item.stream_start ? '0 : pos_q;
		have      = item.stream_start ? 1'b0 : have_q;
		cnt       = item.stream_start ? '0 : cnt_q;
		mstart    = item.stream_start ? '0 : mstart_q;
		diffs_all = {diffs_high_q, diffs_low_q};
		diff      = (cur >= prev_q) ? (cur - prev_q) : (prev_q - cur);
		expected  = diffs_all[8*cnt +: 8];

		if (wl_q < WL_MIN) begin
			len_eff = WL_MIN;
		end else if (wl_q > WL_W'(MAX_WORD)) begin
			len_eff = WL_W'(MAX_WORD);
		end else begin
			len_eff = wl_q;
		end

		hit        = have && (cnt < CW'(MAX_WORD - 1)) && (diff == expected);
		done       = (6'(cnt) + 6'd2) >= {1'b0, len_eff};
		mstart_new = (cnt == '0) ? (addr - ADDRESS_WIDTH'(1)) : mstart;

		ram_we    = accept && hit;
		ram_waddr = cnt;
		ram_wdata = prev_q;

		req.start     = accept && hit && done;
		req.tail_byte = cur;
		req.address   = OUT_ADDR_W'(mstart_new);
		req_last      = cnt + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			have_q   <= 1'b0;
			pos_q    <= '0;
			cnt_q    <= '0;
			mstart_q <= '0;
		end else if (accept) begin
			prev_q <= cur;
			have_q <= 1'b1;
			pos_q  <= addr + ADDRESS_WIDTH'(1);
			if (hit && !done) begin
				cnt_q    <= cnt + CW'(1);
				mstart_q <= mstart_new;
			end else if (have) begin
				// full match or mismatch: drop the run
				cnt_q    <= '0;
				mstart_q <= '0;
			end else begin
				cnt_q    <= cnt;
				mstart_q <= mstart;
			end
		end
	end

endmodule

// File: design/rds_report.sv
// ----------------------------------------------------------------------------
// rds_report
// Report sequencer: reads the stored bytes back, appends the final byte and
// queues the results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module rds_report
	import rds_pkg::*;
#(
	parameter int MAX_WORD = 16,
	localparam int CW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rds_req_t          req,
	input  logic [CW-1:0]     req_last,
	output logic              ram_re,
	output logic [CW-1:0]     ram_raddr,
	input  logic [BYTE_W-1:0] ram_rdata,
	output logic              busy,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item
);

	logic                  busy_q;
	logic [CW-1:0]         ptr_q;
	logic [CW-1:0]         last_q;
	logic [BYTE_W-1:0]     tail_q;
	logic [OUT_ADDR_W-1:0] addr_q;

	logic                  vld_s1;
	logic                  tail_s1;

	out_item_t             buf_q [2];
	logic                  wr_q;
	logic                  rd_q;
	logic [1:0]            occ_q;

	logic                  pop;
	logic                  push;
	logic [1:0]            occ_nxt;
	logic                  issue;
	logic                  is_tail;
	out_item_t             push_item;

	always_comb begin
		pop     = out_valid && out_ready;
		push    = vld_s1;
		occ_nxt = occ_q + 2'(push) - 2'(pop);
		// a read issued now is pushed into the buffer through vld_s1; keep room for it
		issue   = busy_q && (occ_nxt <= 2'd1);
		is_tail = (ptr_q == last_q);

		ram_re    = issue && !is_tail;
		ram_raddr = ptr_q;
		busy      = busy_q;

		push_item.match_address = addr_q;
		push_item.matched_byte  = tail_s1 ? tail_q : ram_rdata;
		push_item.last_byte     = tail_s1;

		out_valid = (occ_q != 2'd0);
		out_item  = buf_q[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			ptr_q   <= '0;
			last_q  <= '0;
			vld_s1  <= 1'b0;
			tail_s1 <= 1'b0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			occ_q   <= 2'd0;
		end else begin
			vld_s1  <= issue;
			tail_s1 <= is_tail;
			if (req.start) begin
				busy_q <= 1'b1;
				ptr_q  <= '0;
				last_q <= req_last;
			end else if (issue) begin
				if (is_tail) begin
					busy_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			occ_q <= occ_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			tail_q <= req.tail_byte;
			addr_q <= req.address;
		end
		if (push) begin
			buf_q[wr_q] <= push_item;
		end
	end

endmodule

// File: design/relative_difference_search_unit.sv
// ----------------------------------------------------------------------------
// relative_difference_search_unit
// Relative search over a byte stream against a word given by differences.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one stream byte per request; stream_start marks the first
//   byte of a new image (address restarts at 0, match cleared). report_out
//   carries one request per matched byte: the address of the first matched
//   byte, the byte itself and last_byte on the final one. The configuration
//   port (cfg_we, cfg_index, cfg_wdata) writes word_length, diffs_low and
//   diffs_high; write it only while the unit is idle.
// Report flow:
//   A byte that does not complete a match is taken one per cycle, back to
//   back. A byte that completes a word of N characters starts a report:
//   N-1 bytes are read from the capture RAM's one read port and the current
//   byte is appended, one per cycle while the output buffer has room; byte_in
//   stalls until the last byte is issued to the output buffer.
// Reset:
//   arst_n clears the match state, the address counter and the output
//   buffer, and loads word_length = 2 with all differences zero. The capture
//   RAM is not cleared; every entry is written before it is read.
// Stall:
//   A stalled receiver holds the two-entry output buffer; the sequencer waits
//   for room, and byte_in stays stalled until the last byte is issued.
// ----------------------------------------------------------------------------
module relative_difference_search_unit
	import rds_pkg::*;
#(
	parameter int MAX_WORD      = 16,
	parameter int ADDRESS_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIFF_W-1:0]    cfg_wdata,
	rds_stream_if.sink           byte_in,
	rds_stream_if.source         report_out
);

	localparam int CW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

	logic              accept;
	logic              ram_we;
	logic [CW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [CW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	rds_req_t          req;
	logic [CW-1:0]     req_last;
	logic              rpt_busy;
	in_item_t          in_item;
	out_item_t         out_item;

	// hold input while a report is being read out of the capture RAM
	assign byte_in.ready   = !rpt_busy;
	assign accept          = byte_in.valid && !rpt_busy;
	assign in_item         = byte_in.data;
	assign report_out.data = out_item;

	rds_scan #(
		.MAX_WORD      (MAX_WORD),
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (in_item),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.req       (req),
		.req_last  (req_last)
	);

	// captured bytes of the current match, entry k = k-th matched byte
	rds_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (1 << CW)
	) u_capture_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rds_report #(
		.MAX_WORD (MAX_WORD)
	) u_report (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_last  (req_last),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.busy      (rpt_busy),
		.out_valid (report_out.valid),
		.out_ready (report_out.ready),
		.out_item  (out_item)
	);

	// a report request only arrives while the sequencer is idle
	a_req_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !rpt_busy)
		else $error("report request while sequencer busy");

	// the sequencer picks up every request
	a_req_taken: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> rpt_busy)
		else $error("report request dropped");

	// the capture RAM is never written while a report reads it
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_busy |-> !ram_we)
		else $error("capture RAM written during report");

endmodule
